// ===== rtl/implicit_list_best_fit_allocator_top_macros.svh =====
// Assertion macros shared by the allocator modules.
`ifndef IMPLICIT_LIST_BEST_FIT_ALLOCATOR_TOP_MACROS_SVH
`define IMPLICIT_LIST_BEST_FIT_ALLOCATOR_TOP_MACROS_SVH

`ifndef ASSERT_OFF
`define ILBF_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ilbf assertion failed");
`define ILBF_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ilbf assertion failed");
`else
`define ILBF_ASSERT_IMPL(lbl, ante, cons)
`define ILBF_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ===== rtl/ilbf_pkg.sv =====
// Types and constants of the best-fit heap allocator.
package ilbf_pkg;

    localparam logic [1:0] MODE_INIT    = 2'd0;
    localparam logic [1:0] MODE_ALLOC   = 2'd1;
    localparam logic [1:0] MODE_FREE    = 2'd2;
    localparam logic [1:0] MODE_REALLOC = 2'd3;

    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_HEAP_BASE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEAP_SIZE = 1'b1;

    localparam int ADDR_W     = 32;
    localparam int BYTES_W    = 13;
    localparam int HDR_BYTES  = 8;
    localparam int ALIGN_BYTES = 8;
    localparam int MIN_HEAP   = 16;
    localparam int SPLIT_MIN  = HDR_BYTES + ALIGN_BYTES;

    typedef struct packed {
        logic [1:0]        mode;
        logic [31:0]       request_size;
        logic [ADDR_W-1:0] address;
    } in_beat_t;

    typedef struct packed {
        logic [ADDR_W-1:0]  payload_address;
        logic               ok;
        logic [BYTES_W-1:0] bytes_used;
    } out_beat_t;

    typedef struct packed {
        logic load;
        logic init;
        logic walk_start;
        logic alloc_step;
        logic alloc_commit;
        logic alloc_split;
        logic free_step;
        logic free_commit;
        logic out_load;
        logic out_ok;
        logic out_grant;
    } cmd_t;

    typedef struct packed {
        logic [1:0] mode;
        logic       formatted;
        logic       req_bad;
        logic       addr_zero;
        logic       init_ok;
        logic       found;
        logic       exact;
        logic       at_end;
        logic       need_split;
        logic       target_hit;
        logic       target_used;
    } status_t;

endpackage

// ===== rtl/implicit_list_best_fit_allocator_top.sv =====
// Top level of the best-fit heap allocator over an implicit block list.
//
//   channel   direction   handshake              beat
//   cfg       in          cfg_we                 cfg_index, cfg_data
//   in        in          in_valid / in_stall    in_data (mode, request_size, address)
//   out       out         out_valid / out_stall  out_data (payload_address, ok, bytes_used)
//
// One request is handled at a time; the header memory gives one read per cycle,
// so a walk reads one header after another, and blocks of at least 16 bytes
// keep a walk to at most HEAP_BYTES / 16 headers. Init and rejected requests go
// from decode straight to the result beat; allocate walks, commits and may split;
// free walks and commits; reallocate allocates, then walks and frees the old block
// if the allocation succeeded and the address is not zero. Reset needs no clearing pass.
// A new request is taken while the previous result beat is still held by out_stall.
module implicit_list_best_fit_allocator_top #(
    parameter int unsigned HEAP_BYTES  = 4096,
    parameter logic [31:0] MAX_REQUEST = 32'd1073741824
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [ilbf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [31:0]                     cfg_data,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  ilbf_pkg::in_beat_t              in_data,
    output logic                            out_valid,
    input  logic                            out_stall,
    output ilbf_pkg::out_beat_t             out_data
);

    ilbf_pkg::cmd_t    cmd;
    ilbf_pkg::status_t st;

    ilbf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .st        (st),
        .cmd       (cmd)
    );

    ilbf_dp #(
        .HEAP_BYTES  (HEAP_BYTES),
        .MAX_REQUEST (MAX_REQUEST)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_data   (in_data),
        .cmd       (cmd),
        .st        (st),
        .out_data  (out_data)
    );

endmodule

// ===== rtl/ilbf_dp.sv =====
// Datapath of the allocator: registers, header memory and walk arithmetic.
`include "implicit_list_best_fit_allocator_top_macros.svh"

module ilbf_dp #(
    parameter int unsigned HEAP_BYTES  = 4096,
    parameter logic [31:0] MAX_REQUEST = 32'd1073741824
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [ilbf_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [31:0]                        cfg_data,
    input  ilbf_pkg::in_beat_t                 in_data,
    input  ilbf_pkg::cmd_t                     cmd,
    output ilbf_pkg::status_t                  st,
    output ilbf_pkg::out_beat_t                out_data
);

    localparam int unsigned SLOTS = HEAP_BYTES / 8;
    localparam int OFF_W = $clog2(HEAP_BYTES) + 1;
    localparam int IDX_W = $clog2(SLOTS);

    logic [31:0]                   base_reg;
    logic [ilbf_pkg::BYTES_W-1:0]  size_reg;
    logic [1:0]                    mode_reg;
    logic [31:0]                   req_reg;
    logic [31:0]                   addr_reg;
    logic [31:0]                   target_reg;
    logic [32:0]                   needed_reg;
    logic [OFF_W-1:0]              off_reg;
    logic [OFF_W-1:0]              best_reg;
    logic [OFF_W-1:0]              best_size_reg;
    logic                          found_reg;
    logic [OFF_W-1:0]              heap_end_reg;
    logic [OFF_W-1:0]              used_reg;
    logic [OFF_W-1:0]              used_next;
    logic                          formatted_reg;
    logic [OFF_W-1:0]              hdr_q_reg;
    ilbf_pkg::out_beat_t           out_data_reg;
    logic [OFF_W-1:0]              mem [SLOTS];

    logic [31:0]      size_w;
    logic [31:0]      size_sat;
    logic [OFF_W-1:0] init_end;
    logic [OFF_W-1:0] hdr_size;
    logic             hdr_used;
    logic [OFF_W:0]   step_sum;
    logic [OFF_W-1:0] next_off;
    logic             fits;
    logic             better;
    logic [OFF_W-1:0] needed_low;
    logic [OFF_W-1:0] diff;
    logic             split;
    logic [OFF_W-1:0] split_off;
    logic [OFF_W-1:0] rd_off;
    logic             wr_en;
    logic [OFF_W-1:0] wr_off;
    logic [OFF_W-1:0] wr_data;
    logic [32:0]      needed_in;
    logic [31:0]      used_w;

    always_comb
    begin
        size_w     = 32'({size_reg[ilbf_pkg::BYTES_W-1:3], 3'b000});
        size_sat   = (size_w > HEAP_BYTES) ? HEAP_BYTES : size_w;
        init_end   = size_sat[OFF_W-1:0];
        hdr_size   = {hdr_q_reg[OFF_W-1:3], 3'b000};
        hdr_used   = hdr_q_reg[0];
        step_sum   = {1'b0, off_reg} + {1'b0, hdr_size}
                   + (OFF_W+1)'(ilbf_pkg::HDR_BYTES);
        next_off   = (step_sum < {1'b0, heap_end_reg}) ? step_sum[OFF_W-1:0] : heap_end_reg;
        fits       = !hdr_used && (33'(hdr_size) >= needed_reg);
        better     = fits && (!found_reg || hdr_size < best_size_reg);
        needed_low = needed_reg[OFF_W-1:0];
        diff       = best_size_reg - needed_low;
        split      = diff >= OFF_W'(ilbf_pkg::SPLIT_MIN);
        split_off  = best_reg + needed_low + OFF_W'(ilbf_pkg::HDR_BYTES);
        rd_off     = cmd.walk_start ? '0 : next_off;
        needed_in  = ({1'b0, in_data.request_size} + 33'(ilbf_pkg::ALIGN_BYTES - 1))
                   & ~33'(ilbf_pkg::ALIGN_BYTES - 1);
        used_w     = 32'(used_reg);
    end

    always_comb
    begin
        wr_en   = 1'b0;
        wr_off  = off_reg;
        wr_data = hdr_size;
        if (cmd.init)
        begin
            wr_en   = 1'b1;
            wr_off  = '0;
            wr_data = init_end - OFF_W'(ilbf_pkg::HDR_BYTES);
        end
        else if (cmd.alloc_commit)
        begin
            wr_en   = 1'b1;
            wr_off  = best_reg;
            wr_data = split ? {needed_low[OFF_W-1:1], 1'b1}
                            : {best_size_reg[OFF_W-1:1], 1'b1};
        end
        else if (cmd.alloc_split)
        begin
            wr_en   = 1'b1;
            wr_off  = split_off;
            wr_data = diff - OFF_W'(ilbf_pkg::HDR_BYTES);
        end
        else if (cmd.free_commit)
        begin
            wr_en   = 1'b1;
            wr_off  = off_reg;
            wr_data = hdr_size;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_off[IDX_W+2:3]] <= wr_data;
        end
        hdr_q_reg <= mem[rd_off[IDX_W+2:3]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg <= '0;
            size_reg <= ilbf_pkg::BYTES_W'(4096);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                ilbf_pkg::CFG_HEAP_BASE: base_reg <= cfg_data;
                ilbf_pkg::CFG_HEAP_SIZE: size_reg <= cfg_data[ilbf_pkg::BYTES_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mode_reg   <= in_data.mode;
            req_reg    <= in_data.request_size;
            addr_reg   <= in_data.address;
            target_reg <= in_data.address - base_reg - 32'(ilbf_pkg::HDR_BYTES);
            needed_reg <= needed_in;
        end
        if (cmd.walk_start)
        begin
            off_reg <= '0;
        end
        else if (cmd.alloc_step || cmd.free_step)
        begin
            off_reg <= next_off;
        end
        if (cmd.alloc_step && better)
        begin
            best_reg      <= off_reg;
            best_size_reg <= hdr_size;
        end
        if (cmd.out_load)
        begin
            out_data_reg.payload_address <= cmd.out_grant
                ? base_reg + 32'(best_reg) + 32'(ilbf_pkg::HDR_BYTES) : '0;
            out_data_reg.ok              <= cmd.out_ok;
            out_data_reg.bytes_used      <= used_w[ilbf_pkg::BYTES_W-1:0];
        end
    end

    always_comb
    begin
        used_next = used_reg;
        if (cmd.init)
        begin
            used_next = '0;
        end
        else if (cmd.alloc_commit)
        begin
            used_next = used_reg + (split ? needed_low : best_size_reg)
                      + OFF_W'(ilbf_pkg::HDR_BYTES);
        end
        else if (cmd.free_commit)
        begin
            used_next = used_reg - hdr_size - OFF_W'(ilbf_pkg::HDR_BYTES);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg      <= '0;
            heap_end_reg  <= '0;
            formatted_reg <= 1'b0;
            found_reg     <= 1'b0;
        end
        else
        begin
            used_reg <= used_next;
            if (cmd.init)
            begin
                heap_end_reg  <= init_end;
                formatted_reg <= 1'b1;
            end
            if (cmd.walk_start)
            begin
                found_reg <= 1'b0;
            end
            else if (cmd.alloc_step && better)
            begin
                found_reg <= 1'b1;
            end
        end
    end

    always_comb
    begin
        st.mode        = mode_reg;
        st.formatted   = formatted_reg;
        st.req_bad     = (req_reg == '0) || (req_reg > MAX_REQUEST);
        st.addr_zero   = (addr_reg == '0);
        st.init_ok     = size_sat >= 32'(ilbf_pkg::MIN_HEAP);
        st.found       = found_reg;
        st.exact       = better && (33'(hdr_size) == needed_reg);
        st.at_end      = (next_off == heap_end_reg);
        st.need_split  = split;
        st.target_hit  = (32'(off_reg) == target_reg);
        st.target_used = hdr_used;
    end

    assign out_data = out_data_reg;

    `ILBF_ASSERT_IMPL(a_used_bound, formatted_reg, used_reg <= heap_end_reg)
    `ILBF_ASSERT_IMPL(a_walk_inside, cmd.alloc_step || cmd.free_step, off_reg < heap_end_reg)
    `ILBF_ASSERT_IMPL(a_split_inside, cmd.alloc_split, split_off < heap_end_reg)

endmodule

// ===== rtl/ilbf_ctrl.sv =====
// Controller of the allocator: sequences decode, walks, commits and the result beat.
`include "implicit_list_best_fit_allocator_top_macros.svh"

module ilbf_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    output logic              out_valid,
    input  logic              out_stall,
    input  ilbf_pkg::status_t st,
    output ilbf_pkg::cmd_t    cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECODE = 3'd1;
    localparam logic [2:0] S_AWALK  = 3'd2;
    localparam logic [2:0] S_AEND   = 3'd3;
    localparam logic [2:0] S_ASPLIT = 3'd4;
    localparam logic [2:0] S_FSTART = 3'd5;
    localparam logic [2:0] S_FWALK  = 3'd6;
    localparam logic [2:0] S_DONE   = 3'd7;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       pend_ok_reg;
    logic       pend_ok_next;
    logic       pend_grant_reg;
    logic       pend_grant_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       chain_free;

    assign chain_free = (st.mode == ilbf_pkg::MODE_REALLOC) && !st.addr_zero;

    always_comb
    begin
        state_next      = state_reg;
        pend_ok_next    = pend_ok_reg;
        pend_grant_next = pend_grant_reg;
        out_valid_next  = out_valid_reg && out_stall;
        cmd             = '0;
        cmd.out_ok      = pend_ok_reg;
        cmd.out_grant   = pend_grant_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load        = 1'b1;
                    pend_ok_next    = 1'b0;
                    pend_grant_next = 1'b0;
                    state_next      = S_DECODE;
                end
            end
            S_DECODE:
            begin
                unique case (st.mode) inside
                    ilbf_pkg::MODE_INIT:
                    begin
                        cmd.init     = st.init_ok;
                        pend_ok_next = st.init_ok;
                        state_next   = S_DONE;
                    end
                    ilbf_pkg::MODE_ALLOC, ilbf_pkg::MODE_REALLOC:
                    begin
                        if (!st.formatted || st.req_bad)
                        begin
                            state_next = S_DONE;
                        end
                        else
                        begin
                            cmd.walk_start = 1'b1;
                            state_next     = S_AWALK;
                        end
                    end
                    ilbf_pkg::MODE_FREE:
                    begin
                        if (st.addr_zero || !st.formatted)
                        begin
                            pend_ok_next = st.addr_zero && st.formatted;
                            state_next   = S_DONE;
                        end
                        else
                        begin
                            cmd.walk_start = 1'b1;
                            state_next     = S_FWALK;
                        end
                    end
                    default: state_next = S_DONE;
                endcase
            end
            S_AWALK:
            begin
                cmd.alloc_step = 1'b1;
                if (st.exact || st.at_end)
                begin
                    state_next = S_AEND;
                end
            end
            S_AEND:
            begin
                if (!st.found)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.alloc_commit = 1'b1;
                    pend_ok_next     = 1'b1;
                    pend_grant_next  = 1'b1;
                    if (st.need_split)
                    begin
                        state_next = S_ASPLIT;
                    end
                    else if (chain_free)
                    begin
                        state_next = S_FSTART;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end
            S_ASPLIT:
            begin
                cmd.alloc_split = 1'b1;
                state_next      = chain_free ? S_FSTART : S_DONE;
            end
            S_FSTART:
            begin
                cmd.walk_start = 1'b1;
                state_next     = S_FWALK;
            end
            S_FWALK:
            begin
                cmd.free_step = 1'b1;
                if (st.target_hit)
                begin
                    if (st.target_used)
                    begin
                        cmd.free_commit = 1'b1;
                        if (st.mode == ilbf_pkg::MODE_FREE)
                        begin
                            pend_ok_next = 1'b1;
                        end
                    end
                    state_next = S_DONE;
                end
                else if (st.at_end)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            pend_ok_reg    <= 1'b0;
            pend_grant_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            pend_ok_reg    <= pend_ok_next;
            pend_grant_reg <= pend_grant_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

    `ILBF_ASSERT_IMPL(a_commit_found, cmd.alloc_commit, st.found)
    `ILBF_ASSERT_IMPL(a_one_write, 1'b1, $onehot0({cmd.init, cmd.alloc_commit, cmd.alloc_split, cmd.free_commit}))
    `ILBF_ASSERT_IMPL(a_load_slot, cmd.out_load, !out_valid_reg || !out_stall)
    `ILBF_ASSERT_NEXT(a_load_shows, cmd.out_load, out_valid_reg && state_reg == S_IDLE)

endmodule

// ===== tb/sv/implicit_list_best_fit_allocator_top_tb.sv =====
// Self-checking testbench for the best-fit heap allocator with its own heap predictor.
module implicit_list_best_fit_allocator_top_tb;

    localparam int unsigned HEAP_BYTES  = 4096;
    localparam logic [31:0] MAX_REQUEST = 32'd1073741824;
    localparam int unsigned SLOTS       = HEAP_BYTES / 8;
    localparam int          STUCK_LIMIT = 20000;

    logic                           clk       = 1'b0;
    logic                           rst_n     = 1'b0;
    logic                           cfg_we    = 1'b0;
    logic [ilbf_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [31:0]                    cfg_data  = '0;
    logic                           in_valid  = 1'b0;
    logic                           in_stall;
    ilbf_pkg::in_beat_t             in_data   = '0;
    logic                           out_valid;
    logic                           out_stall = 1'b0;
    ilbf_pkg::out_beat_t            out_data;

    logic [12:0] hdr_mem [SLOTS];
    int unsigned used_total;
    int unsigned heap_len;
    bit          heap_ready;
    logic [31:0] base_reg;
    logic [12:0] size_reg;

    ilbf_pkg::out_beat_t expected_outcomes [$];
    ilbf_pkg::out_beat_t oldest;

    int send_idle_pct = 0;
    int stall_pct     = 0;
    int mismatches    = 0;
    int beats_sent    = 0;
    int beats_checked = 0;
    int beats_ok      = 0;
    int layouts       = 0;
    int stuck_cycles  = 0;

    implicit_list_best_fit_allocator_top #(
        .HEAP_BYTES  (HEAP_BYTES),
        .MAX_REQUEST (MAX_REQUEST)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    always #5 clk = ~clk;

    function automatic int unsigned hdr_size(input int unsigned off);
        return {19'd0, hdr_mem[(off >> 3) % SLOTS]} & 32'hFFFF_FFF8;
    endfunction

    function automatic bit hdr_used(input int unsigned off);
        return hdr_mem[(off >> 3) % SLOTS][0];
    endfunction

    function automatic void hdr_write(input int unsigned off, input int unsigned val);
        hdr_mem[(off >> 3) % SLOTS] = val[12:0];
    endfunction

    function automatic int unsigned walk_next(input int unsigned off);
        int unsigned nxt;
        nxt = off + hdr_size(off) + ilbf_pkg::HDR_BYTES;
        return (nxt < heap_len) ? nxt : heap_len;
    endfunction

    function automatic bit find_fit(input longint unsigned req, output int unsigned got);
        longint unsigned needed;
        int unsigned     off;
        int unsigned     best;
        int unsigned     best_size;
        int unsigned     sz;
        int unsigned     diff;
        int unsigned     guard;
        bit              found;
        bit              exact_hit;
        got = 0;
        if (!heap_ready || req == 0 || req > MAX_REQUEST)
            return 1'b0;
        needed    = (req + ilbf_pkg::ALIGN_BYTES - 1) & ~64'd7;
        off       = 0;
        guard     = 0;
        best      = 0;
        best_size = 0;
        found     = 1'b0;
        exact_hit = 1'b0;
        while (!exact_hit && off < heap_len && guard < SLOTS)
        begin
            sz = hdr_size(off);
            if (!hdr_used(off) && sz >= needed && (!found || sz < best_size))
            begin
                found     = 1'b1;
                best      = off;
                best_size = sz;
                exact_hit = (sz == needed);
            end
            off = walk_next(off);
            guard++;
        end
        if (!found)
            return 1'b0;
        diff = best_size - needed[31:0];
        if (diff >= ilbf_pkg::SPLIT_MIN)
        begin
            hdr_write(best + ilbf_pkg::HDR_BYTES + needed[31:0], diff - ilbf_pkg::HDR_BYTES);
            hdr_write(best, needed[31:0] | 32'h1);
            used_total += needed[31:0] + ilbf_pkg::HDR_BYTES;
        end
        else
        begin
            hdr_write(best, best_size | 32'h1);
            used_total += best_size + ilbf_pkg::HDR_BYTES;
        end
        got = best;
        return 1'b1;
    endfunction

    function automatic bit release_block(input logic [31:0] addr);
        int unsigned target;
        int unsigned off;
        int unsigned guard;
        int unsigned sz;
        if (!heap_ready)
            return 1'b0;
        target = addr - base_reg - ilbf_pkg::HDR_BYTES;
        off    = 0;
        guard  = 0;
        while (off < heap_len && guard < SLOTS)
        begin
            if (off == target)
            begin
                if (!hdr_used(off))
                    return 1'b0;
                sz = hdr_size(off);
                hdr_write(off, sz);
                used_total -= sz + ilbf_pkg::HDR_BYTES;
                return 1'b1;
            end
            off = walk_next(off);
            guard++;
        end
        return 1'b0;
    endfunction

    function automatic ilbf_pkg::out_beat_t predict_outcome(input ilbf_pkg::in_beat_t b);
        ilbf_pkg::out_beat_t r;
        int unsigned         sz;
        int unsigned         got;
        r.payload_address = '0;
        r.ok              = 1'b0;
        case (b.mode)
            ilbf_pkg::MODE_INIT:
            begin
                sz = {19'd0, size_reg} & 32'hFFFF_FFF8;
                if (sz > HEAP_BYTES)
                    sz = HEAP_BYTES;
                if (sz >= ilbf_pkg::MIN_HEAP)
                begin
                    heap_len = sz;
                    hdr_write(0, sz - ilbf_pkg::HDR_BYTES);
                    used_total = 0;
                    heap_ready = 1'b1;
                    r.ok       = 1'b1;
                end
            end
            ilbf_pkg::MODE_ALLOC:
            begin
                if (find_fit({32'd0, b.request_size}, got))
                begin
                    r.ok              = 1'b1;
                    r.payload_address = base_reg + got + ilbf_pkg::HDR_BYTES;
                end
            end
            ilbf_pkg::MODE_FREE:
            begin
                if (b.address == '0)
                    r.ok = heap_ready;
                else
                    r.ok = release_block(b.address);
            end
            default:
            begin
                if (find_fit({32'd0, b.request_size}, got))
                begin
                    r.ok              = 1'b1;
                    r.payload_address = base_reg + got + ilbf_pkg::HDR_BYTES;
                    if (b.address != '0)
                        void'(release_block(b.address));
                end
            end
        endcase
        r.bytes_used = used_total[12:0];
        return r;
    endfunction

    function automatic logic [31:0] pick_used_payload();
        int unsigned off;
        int unsigned guard;
        int unsigned count;
        int unsigned pick;
        off   = 0;
        guard = 0;
        count = 0;
        while (heap_ready && off < heap_len && guard < SLOTS)
        begin
            if (hdr_used(off))
                count++;
            off = walk_next(off);
            guard++;
        end
        if (count == 0)
            return '0;
        pick  = $urandom_range(count - 1);
        off   = 0;
        guard = 0;
        count = 0;
        while (off < heap_len && guard < SLOTS)
        begin
            if (hdr_used(off))
            begin
                if (count == pick)
                    return base_reg + off + ilbf_pkg::HDR_BYTES;
                count++;
            end
            off = walk_next(off);
            guard++;
        end
        return '0;
    endfunction

    function automatic logic [31:0] pick_stray_address();
        case ($urandom_range(2))
            0:       return $urandom();
            1:       return base_reg + 8 * $urandom_range(heap_len / 8);
            default: return pick_used_payload() + 32'd4;
        endcase
    endfunction

    function automatic logic [31:0] pick_request();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 60)
            return $urandom_range(64, 1);
        else if (r < 78)
            return $urandom_range(HEAP_BYTES, 1);
        else if (r < 84)
            return '0;
        else if (r < 90)
            return MAX_REQUEST + $urandom_range(1000, 1);
        else if (r < 96)
            return $urandom();
        else
            return MAX_REQUEST;
    endfunction

    function automatic ilbf_pkg::in_beat_t make_beat(input logic [1:0] mode,
                                                     input logic [31:0] req,
                                                     input logic [31:0] addr);
        ilbf_pkg::in_beat_t b;
        b.mode         = mode;
        b.request_size = req;
        b.address      = addr;
        return b;
    endfunction

    function automatic ilbf_pkg::in_beat_t random_op();
        ilbf_pkg::in_beat_t b;
        int unsigned        r;
        b = make_beat(ilbf_pkg::MODE_ALLOC, pick_request(), $urandom());
        r = $urandom_range(99);
        if (r < 40)
            b.mode = ilbf_pkg::MODE_ALLOC;
        else if (r < 68)
            b = make_beat(ilbf_pkg::MODE_FREE, $urandom(), pick_used_payload());
        else if (r < 82)
            b = make_beat(ilbf_pkg::MODE_REALLOC, b.request_size, pick_used_payload());
        else if (r < 88)
            b = make_beat(ilbf_pkg::MODE_FREE, $urandom(), pick_stray_address());
        else if (r < 92)
            b = make_beat(ilbf_pkg::MODE_REALLOC, b.request_size, pick_stray_address());
        else if (r < 95)
            b = make_beat(ilbf_pkg::MODE_REALLOC, b.request_size, '0);
        else if (r < 97)
            b.mode = ilbf_pkg::MODE_INIT;
        else
            b = make_beat(ilbf_pkg::MODE_FREE, $urandom(), '0);
        return b;
    endfunction

    task automatic send_beat(input ilbf_pkg::in_beat_t b);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        expected_outcomes.push_back(predict_outcome(b));
        beats_sent++;
    endtask

    task automatic write_reg(input logic [ilbf_pkg::CFG_IDX_W-1:0] idx,
                             input logic [31:0] val);
        in_valid <= 1'b0;
        while (expected_outcomes.size() != 0)
            @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == ilbf_pkg::CFG_HEAP_BASE)
            base_reg = val;
        else
            size_reg = val[12:0];
        @(posedge clk);
    endtask

    task automatic test_before_init();
        send_beat(make_beat(ilbf_pkg::MODE_ALLOC, 32'd8, 32'd0));
        send_beat(make_beat(ilbf_pkg::MODE_FREE, 32'd0, 32'd0));
        send_beat(make_beat(ilbf_pkg::MODE_FREE, 32'd0, 32'd8));
        send_beat(make_beat(ilbf_pkg::MODE_REALLOC, 32'd8, 32'd0));
        write_reg(ilbf_pkg::CFG_HEAP_SIZE, 32'd8);
        send_beat(make_beat(ilbf_pkg::MODE_INIT, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    endtask

    task automatic test_limits();
        write_reg(ilbf_pkg::CFG_HEAP_BASE, 32'hFFFF_FFFC);
        write_reg(ilbf_pkg::CFG_HEAP_SIZE, 32'h1FFF);
        send_beat(make_beat(ilbf_pkg::MODE_INIT, 32'd0, 32'd0));
        send_beat(make_beat(ilbf_pkg::MODE_ALLOC, 32'hFFFF_FFFF, 32'd0));
        send_beat(make_beat(ilbf_pkg::MODE_ALLOC, 32'd0, 32'd0));
        send_beat(make_beat(ilbf_pkg::MODE_ALLOC, MAX_REQUEST + 32'd1, 32'd0));
        send_beat(make_beat(ilbf_pkg::MODE_ALLOC, MAX_REQUEST, 32'd0));
        send_beat(make_beat(ilbf_pkg::MODE_ALLOC, 32'd4088, 32'd0));
        send_beat(make_beat(ilbf_pkg::MODE_ALLOC, 32'd1, 32'd0));
        send_beat(make_beat(ilbf_pkg::MODE_FREE, 32'd0, 32'd4));
    endtask

    task automatic test_split_and_reuse();
        write_reg(ilbf_pkg::CFG_HEAP_BASE, 32'h0000_1000);
        write_reg(ilbf_pkg::CFG_HEAP_SIZE, 32'd69);
        send_beat(make_beat(ilbf_pkg::MODE_INIT, 32'd0, 32'd0));
        send_beat(make_beat(ilbf_pkg::MODE_ALLOC, 32'd8, 32'd0));
        send_beat(make_beat(ilbf_pkg::MODE_ALLOC, 32'd24, 32'd0));
        send_beat(make_beat(ilbf_pkg::MODE_ALLOC, 32'd8, 32'd0));
        send_beat(make_beat(ilbf_pkg::MODE_FREE, 32'd0, 32'h0000_1018));
        send_beat(make_beat(ilbf_pkg::MODE_FREE, 32'd0, 32'h0000_1018));
        send_beat(make_beat(ilbf_pkg::MODE_FREE, 32'd0, 32'h0000_1019));
        send_beat(make_beat(ilbf_pkg::MODE_FREE, 32'd0, 32'd0));
        send_beat(make_beat(ilbf_pkg::MODE_ALLOC, 32'd16, 32'd0));
        send_beat(make_beat(ilbf_pkg::MODE_FREE, 32'd0, 32'h0000_1008));
        send_beat(make_beat(ilbf_pkg::MODE_FREE, 32'd0, 32'h0000_1038));
        send_beat(make_beat(ilbf_pkg::MODE_REALLOC, 32'd8, 32'h0000_1018));
        send_beat(make_beat(ilbf_pkg::MODE_REALLOC, 32'd8, 32'h0000_1038));
        send_beat(make_beat(ilbf_pkg::MODE_REALLOC, 32'd16, 32'h0000_2000));
        send_beat(make_beat(ilbf_pkg::MODE_REALLOC, 32'd100, 32'h0000_1008));
    endtask

    task automatic test_random_traffic(input int idle_pct, input int hold_pct, input int count);
        int                 left;
        int                 ops;
        logic [31:0]        base_val;
        logic [12:0]        size_val;
        ilbf_pkg::in_beat_t b;
        left          = count;
        send_idle_pct = idle_pct;
        stall_pct     = hold_pct;
        while (left > 0)
        begin
            case ($urandom_range(7))
                0:       base_val = 32'h0;
                1:       base_val = 32'hFFFF_FFFF;
                default: base_val = $urandom();
            endcase
            case ($urandom_range(19))
                0:       size_val = 13'h1FFF;
                1:       size_val = 13'd4096;
                2:       size_val = 13'($urandom_range(15));
                3:       size_val = 13'd16;
                4:       size_val = 13'($urandom_range(8191, 4097));
                default: size_val = 13'($urandom_range(512, 16));
            endcase
            write_reg(ilbf_pkg::CFG_HEAP_BASE, base_val);
            write_reg(ilbf_pkg::CFG_HEAP_SIZE, {19'd0, size_val});
            layouts++;
            b = make_beat(ilbf_pkg::MODE_INIT, $urandom(), $urandom());
            send_beat(b);
            left--;
            ops = $urandom_range(90, 30);
            while (ops > 0 && left > 0)
            begin
                send_beat(random_op());
                ops--;
                left--;
            end
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            beats_checked++;
            if (expected_outcomes.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat: addr %h ok %0b used %0d",
                             out_data.payload_address, out_data.ok, out_data.bytes_used);
            end
            else
            begin
                oldest = expected_outcomes.pop_front();
                if (oldest.ok)
                    beats_ok++;
                if (out_data.payload_address !== oldest.payload_address ||
                    out_data.ok !== oldest.ok || out_data.bytes_used !== oldest.bytes_used)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"result beat %0d: expected addr %h ok %0b used %0d, ",
                                  "got addr %h ok %0b used %0d"},
                                 beats_checked, oldest.payload_address, oldest.ok,
                                 oldest.bytes_used, out_data.payload_address, out_data.ok,
                                 out_data.bytes_used);
                end
            end
        end
        out_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
            stuck_cycles <= 0;
        else
            stuck_cycles <= stuck_cycles + 1;
    end

    initial
    begin
        wait (stuck_cycles >= STUCK_LIMIT);
        $display("watchdog: no beat moved for %0d cycles", STUCK_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        base_reg   = '0;
        size_reg   = 13'd4096;
        used_total = 0;
        heap_len   = 0;
        heap_ready = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_before_init();
        test_limits();
        test_split_and_reuse();
        test_random_traffic(0, 0, 280);
        test_random_traffic(74, 0, 280);
        test_random_traffic(0, 74, 280);
        test_random_traffic(24, 24, 280);
        in_valid <= 1'b0;
        while (expected_outcomes.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        $display("Sent %0d request beats over %0d random heap layouts plus directed cases,",
                 beats_sent, layouts);
        $display("with four idle and stall mixes; %0d result beats checked, %0d succeeded.",
                 beats_checked, beats_ok);
        if (mismatches == 0 && expected_outcomes.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/ilbf_pkg.sv
rtl/ilbf_dp.sv
rtl/ilbf_ctrl.sv
rtl/implicit_list_best_fit_allocator_top.sv
tb/sv/implicit_list_best_fit_allocator_top_tb.sv
